// ----- sv/sorted_range_table_engine_unit_macros.svh -----
// assertion helpers used by the block's datapath module
`ifndef SORTED_RANGE_TABLE_ENGINE_UNIT_MACROS_SVH
`define SORTED_RANGE_TABLE_ENGINE_UNIT_MACROS_SVH

// clocked check, off while reset is asserted
`define SRTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SRTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srte_pkg.sv -----
package srte_pkg;

    localparam int MAX_CELLS  = 255;
    localparam int PAGE_SHIFT = 12;
    localparam int VA_W       = 48;
    localparam int PA_W       = 56;
    localparam int PERM_W     = 8;
    localparam int OUT_IDX_W  = 8;
    localparam int VPN_W      = VA_W - PAGE_SHIFT;
    localparam int PPN_W      = PA_W - PAGE_SHIFT;
    localparam int ADDR_W     = $clog2(MAX_CELLS + 1);
    localparam int CNT_W      = $clog2(MAX_CELLS + 2);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_MAP    = 2'd1,
        OP_UNMAP  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MAPPED   = 2'd1,
        ST_UNMAPPED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [VPN_W-1:0]  base;
        logic [VPN_W-1:0]  fin;
        logic [PPN_W-1:0]  ppn;
        logic [PERM_W-1:0] perms;
    } cell_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_PROBE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_CMP,
        S_CHKFULL,
        S_UP,
        S_UP_WR,
        S_INS,
        S_DN,
        S_DN_WR,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RDS_MID,
        RDS_POS,
        RDS_K,
        RDS_K1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WRS_UP,
        WRS_DN,
        WRS_NEW
    } wr_sel_t;

    typedef enum logic [1:0] {
        RI_ZERO,
        RI_HIT,
        RI_POS
    } resp_idx_t;

    typedef struct packed {
        logic      load;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      lo_step;
        logic      hi_step;
        logic      hit_set;
        logic      pos_init;
        logic      pos_inc;
        logic      k_from_cnt;
        logic      k_from_hit;
        logic      k_dec;
        logic      k_inc;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      resp_en;
        status_t   resp_status;
        resp_idx_t resp_idx;
        logic      resp_phys;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic srch_more;
        logic pg_ge_end;
        logic pg_lt_base;
        logic hit_nz;
        logic pos_le_cnt;
        logic end_gt_base;
        logic full;
        logic up_more;
        logic dn_more;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/srte_ctrl.sv -----
module srte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  srte_pkg::stat_t stat,
    output srte_pkg::cmd_t  cmd
);

    srte_pkg::state_t state_reg;
    srte_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srte_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = srte_pkg::RDS_MID;
        cmd.wr_sel      = srte_pkg::WRS_UP;
        cmd.resp_status = srte_pkg::ST_UNMAPPED;
        cmd.resp_idx    = srte_pkg::RI_ZERO;
        in_ready        = 1'b0;
        unique case (state_reg)
            srte_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = srte_pkg::S_SRCH;
                end
            end
            srte_pkg::S_SRCH:
            begin
                if (stat.srch_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srte_pkg::RDS_MID;
                    state_next = srte_pkg::S_PROBE;
                end
                else
                begin
                    state_next = srte_pkg::S_DISPATCH;
                end
            end
            srte_pkg::S_PROBE:
            begin
                if (stat.pg_ge_end)
                begin
                    cmd.lo_step = 1'b1;
                    state_next  = srte_pkg::S_SRCH;
                end
                else if (stat.pg_lt_base)
                begin
                    cmd.hi_step = 1'b1;
                    state_next  = srte_pkg::S_SRCH;
                end
                else
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = srte_pkg::S_DISPATCH;
                end
            end
            srte_pkg::S_DISPATCH:
            begin
                unique case (stat.op)
                    srte_pkg::OP_LOOKUP:
                    begin
                        cmd.resp_en     = 1'b1;
                        cmd.resp_status = stat.hit_nz ? srte_pkg::ST_OK
                                                      : srte_pkg::ST_UNMAPPED;
                        cmd.resp_idx    = srte_pkg::RI_HIT;
                        state_next      = srte_pkg::S_RESP;
                    end
                    srte_pkg::OP_MAP:
                    begin
                        if (stat.hit_nz)
                        begin
                            cmd.resp_en     = 1'b1;
                            cmd.resp_status = srte_pkg::ST_MAPPED;
                            cmd.resp_idx    = srte_pkg::RI_HIT;
                            state_next      = srte_pkg::S_RESP;
                        end
                        else
                        begin
                            cmd.pos_init = 1'b1;
                            state_next   = srte_pkg::S_SCAN;
                        end
                    end
                    srte_pkg::OP_UNMAP:
                    begin
                        if (stat.hit_nz)
                        begin
                            cmd.k_from_hit = 1'b1;
                            state_next     = srte_pkg::S_DN;
                        end
                        else
                        begin
                            cmd.resp_en = 1'b1;
                            state_next  = srte_pkg::S_RESP;
                        end
                    end
                    default:
                    begin
                        cmd.resp_en = 1'b1;
                        state_next  = srte_pkg::S_RESP;
                    end
                endcase
            end
            srte_pkg::S_SCAN:
            begin
                if (stat.pos_le_cnt)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srte_pkg::RDS_POS;
                    state_next = srte_pkg::S_SCAN_CMP;
                end
                else
                begin
                    state_next = srte_pkg::S_CHKFULL;
                end
            end
            srte_pkg::S_SCAN_CMP:
            begin
                // cell pos ends at or below the page: keep walking
                if (stat.pg_ge_end)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = srte_pkg::S_SCAN;
                end
                else if (stat.end_gt_base)
                begin
                    cmd.resp_en     = 1'b1;
                    cmd.resp_status = srte_pkg::ST_MAPPED;
                    cmd.resp_idx    = srte_pkg::RI_POS;
                    state_next      = srte_pkg::S_RESP;
                end
                else
                begin
                    state_next = srte_pkg::S_CHKFULL;
                end
            end
            srte_pkg::S_CHKFULL:
            begin
                if (stat.full)
                begin
                    cmd.resp_en     = 1'b1;
                    cmd.resp_status = srte_pkg::ST_FULL;
                    state_next      = srte_pkg::S_RESP;
                end
                else
                begin
                    cmd.k_from_cnt = 1'b1;
                    state_next     = srte_pkg::S_UP;
                end
            end
            srte_pkg::S_UP:
            begin
                if (stat.up_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srte_pkg::RDS_K;
                    state_next = srte_pkg::S_UP_WR;
                end
                else
                begin
                    state_next = srte_pkg::S_INS;
                end
            end
            srte_pkg::S_UP_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = srte_pkg::WRS_UP;
                cmd.k_dec  = 1'b1;
                state_next = srte_pkg::S_UP;
            end
            srte_pkg::S_INS:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = srte_pkg::WRS_NEW;
                cmd.cnt_inc     = 1'b1;
                cmd.resp_en     = 1'b1;
                cmd.resp_status = srte_pkg::ST_OK;
                cmd.resp_idx    = srte_pkg::RI_POS;
                cmd.resp_phys   = 1'b1;
                state_next      = srte_pkg::S_RESP;
            end
            srte_pkg::S_DN:
            begin
                if (stat.dn_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srte_pkg::RDS_K1;
                    state_next = srte_pkg::S_DN_WR;
                end
                else
                begin
                    cmd.cnt_dec     = 1'b1;
                    cmd.resp_en     = 1'b1;
                    cmd.resp_status = srte_pkg::ST_OK;
                    cmd.resp_idx    = srte_pkg::RI_HIT;
                    state_next      = srte_pkg::S_RESP;
                end
            end
            srte_pkg::S_DN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = srte_pkg::WRS_DN;
                cmd.k_inc  = 1'b1;
                state_next = srte_pkg::S_DN;
            end
            srte_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = srte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srte_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/srte_dp.sv -----
`include "sorted_range_table_engine_unit_macros.svh"

module srte_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srte_pkg::cmd_t                cmd,
    output srte_pkg::stat_t               stat,
    input  logic [1:0]                    opcode,
    input  logic [srte_pkg::VA_W-1:0]     virt_addr,
    input  logic [srte_pkg::PA_W-1:0]     phys_addr,
    input  logic [srte_pkg::VA_W-1:0]     range_length,
    input  logic [srte_pkg::PERM_W-1:0]   perm_flags,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [srte_pkg::OUT_IDX_W-1:0] cell_index,
    output logic [srte_pkg::PA_W-1:0]     mapped_phys
);

    srte_pkg::cell_t mem [0:srte_pkg::MAX_CELLS];
    srte_pkg::cell_t rdata_reg;

    srte_pkg::op_t                    op_reg;
    logic [srte_pkg::VPN_W-1:0]       page_reg;
    logic [srte_pkg::VPN_W-1:0]       end_page_reg;
    logic [srte_pkg::PA_W-1:0]        pa_reg;
    logic [srte_pkg::PERM_W-1:0]      perm_reg;
    logic [srte_pkg::CNT_W-1:0]       cnt_reg;
    logic [srte_pkg::CNT_W-1:0]       lo_reg;
    logic [srte_pkg::CNT_W-1:0]       hi_reg;
    logic [srte_pkg::CNT_W-1:0]       hit_reg;
    logic [srte_pkg::CNT_W-1:0]       pos_reg;
    logic [srte_pkg::CNT_W-1:0]       k_reg;
    srte_pkg::status_t                resp_st_reg;
    logic [srte_pkg::CNT_W-1:0]       resp_idx_reg;
    logic [srte_pkg::PA_W-1:0]        resp_pa_reg;
    logic                             out_valid_reg;
    srte_pkg::status_t                out_st_reg;
    logic [srte_pkg::OUT_IDX_W-1:0]   out_idx_reg;
    logic [srte_pkg::PA_W-1:0]        out_pa_reg;

    logic [srte_pkg::CNT_W-1:0]       mid;
    logic [srte_pkg::CNT_W-1:0]       rd_idx;
    logic [srte_pkg::CNT_W-1:0]       wr_idx;
    srte_pkg::cell_t                  wr_data;
    logic [srte_pkg::VA_W:0]          end_sum;
    logic [srte_pkg::VA_W-1:0]        end_sat;
    logic [srte_pkg::CNT_W-1:0]       ri;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign end_sum = {1'b0, virt_addr} + {1'b0, range_length};
    // end address clamps to the top of the address space
    assign end_sat = end_sum[srte_pkg::VA_W] ? {srte_pkg::VA_W{1'b1}}
                                             : end_sum[srte_pkg::VA_W-1:0];

    always_comb
    begin
        case (cmd.rd_sel)
            srte_pkg::RDS_MID: rd_idx = mid;
            srte_pkg::RDS_POS: rd_idx = pos_reg;
            srte_pkg::RDS_K:   rd_idx = k_reg;
            default:           rd_idx = k_reg + 1'b1;
        endcase
        case (cmd.wr_sel)
            srte_pkg::WRS_UP:
            begin
                wr_idx  = k_reg + 1'b1;
                wr_data = rdata_reg;
            end
            srte_pkg::WRS_DN:
            begin
                wr_idx  = k_reg;
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_idx        = pos_reg;
                wr_data.base  = page_reg;
                wr_data.fin   = end_page_reg;
                wr_data.ppn   = pa_reg[srte_pkg::PA_W-1:srte_pkg::PAGE_SHIFT];
                wr_data.perms = perm_reg;
            end
        endcase
        case (cmd.resp_idx)
            srte_pkg::RI_HIT: ri = hit_reg;
            srte_pkg::RI_POS: ri = pos_reg;
            default:          ri = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_idx[srte_pkg::ADDR_W-1:0]];
        end
        if (cmd.wr_en)
        begin
            mem[wr_idx[srte_pkg::ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= srte_pkg::op_t'(opcode);
            page_reg     <= virt_addr[srte_pkg::VA_W-1:srte_pkg::PAGE_SHIFT];
            end_page_reg <= end_sat[srte_pkg::VA_W-1:srte_pkg::PAGE_SHIFT];
            pa_reg       <= phys_addr;
            perm_reg     <= perm_flags;
            lo_reg       <= srte_pkg::CNT_W'(1);
            hi_reg       <= cnt_reg + 1'b1;
            hit_reg      <= '0;
        end
        else
        begin
            if (cmd.lo_step)
            begin
                lo_reg <= mid + 1'b1;
            end
            if (cmd.hi_step)
            begin
                hi_reg <= mid;
            end
            if (cmd.hit_set)
            begin
                hit_reg <= mid;
            end
        end
        if (cmd.pos_init)
        begin
            pos_reg <= srte_pkg::CNT_W'(1);
        end
        else if (cmd.pos_inc)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.k_from_cnt)
        begin
            k_reg <= cnt_reg;
        end
        else if (cmd.k_from_hit)
        begin
            k_reg <= hit_reg;
        end
        else if (cmd.k_dec)
        begin
            k_reg <= k_reg - 1'b1;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.resp_en)
        begin
            resp_st_reg  <= cmd.resp_status;
            resp_idx_reg <= ri;
            resp_pa_reg  <= cmd.resp_phys ? pa_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_st_reg  <= resp_st_reg;
            out_idx_reg <= srte_pkg::OUT_IDX_W'(resp_idx_reg);
            out_pa_reg  <= resp_pa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op          = op_reg;
    assign stat.srch_more   = lo_reg < hi_reg;
    assign stat.pg_ge_end   = page_reg >= rdata_reg.fin;
    assign stat.pg_lt_base  = page_reg < rdata_reg.base;
    assign stat.hit_nz      = hit_reg != '0;
    assign stat.pos_le_cnt  = pos_reg <= cnt_reg;
    assign stat.end_gt_base = end_page_reg > rdata_reg.base;
    assign stat.full        = cnt_reg >= srte_pkg::CNT_W'(srte_pkg::MAX_CELLS);
    assign stat.up_more     = k_reg >= pos_reg;
    assign stat.dn_more     = k_reg < cnt_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign cell_index  = out_idx_reg;
    assign mapped_phys = out_pa_reg;

    `SRTE_ASSERT(a_cnt_bound, cnt_reg <= srte_pkg::CNT_W'(srte_pkg::MAX_CELLS), "cell count overflow")
    `SRTE_ASSERT(a_wr_in_table, !cmd.wr_en || (wr_idx != '0 && wr_idx <= cnt_reg + 1'b1), "write outside table")
    `SRTE_ASSERT_NEXT(a_cnt_inc, cmd.cnt_inc, cnt_reg == $past(cnt_reg) + 1'b1, "count did not grow")
    `SRTE_ASSERT_NEXT(a_unmap_ok, cmd.cnt_dec, resp_st_reg == srte_pkg::ST_OK && resp_idx_reg != '0, "removal without hit")

endmodule

// ----- sv/sorted_range_table_engine_unit.sv -----
// Sorted address-range translation table with up to 255 cells, numbered from 1, held in a
// single-port cell memory with a registered read. Every operation starts with a binary
// search of the cells. A map also walks the cells from 1 to its insert point and moves every
// cell above it up one place. An unmap searches, then moves the cells above the removed one
// down. One item is worked on at a time; a new item is taken as soon as the previous result
// is handed to the output register, even while that result still waits to be taken.
module sorted_range_table_engine_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [srte_pkg::VA_W-1:0]      virt_addr,
    input  logic [srte_pkg::PA_W-1:0]      phys_addr,
    input  logic [srte_pkg::VA_W-1:0]      range_length,
    input  logic [srte_pkg::PERM_W-1:0]    perm_flags,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [srte_pkg::OUT_IDX_W-1:0] cell_index,
    output logic [srte_pkg::PA_W-1:0]      mapped_phys
);

    srte_pkg::cmd_t  cmd;
    srte_pkg::stat_t stat;

    srte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srte_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .range_length (range_length),
        .perm_flags   (perm_flags),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cell_index   (cell_index),
        .mapped_phys  (mapped_phys)
    );

endmodule
